// ===== rtl/lidar_packet_decoder_assert.svh =====
// Assertion macros shared by the lidar packet decoder RTL.
`ifndef LIDAR_PACKET_DECODER_ASSERT_SVH
`define LIDAR_PACKET_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define LPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("lpd check failed");
`define LPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("lpd check failed");
`else
`define LPD_ASSERT(lbl, prop)
`define LPD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/lpd_pkg.sv =====
// Shared constants, types and state codes of the lidar packet decoder.
package lpd_pkg;

  localparam int PACKET_LENGTH = 22;
  localparam int POS_W         = $clog2(PACKET_LENGTH);
  localparam int ANGLE_BINS    = 360;
  localparam int ANG_W         = $clog2(ANGLE_BINS);
  localparam int RAW_ANG_W     = 10;
  localparam int DIST_W        = 14;
  localparam int SPEED_W       = 16;
  localparam int MEAS_PER_PKT  = 4;
  localparam int MEAS_IDX_W    = $clog2(MEAS_PER_PKT);

  localparam logic [7:0]        START_BYTE    = 8'hFA;
  localparam logic [7:0]        ANGLE_BASE    = 8'hA0;
  localparam int                INVALID_BIT   = 7;
  localparam logic [DIST_W-1:0] CEILING_RESET = 14'd2000;

  // Input mode and result kind codes
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_SCAN = 1'b1;
  localparam logic KIND_MEAS = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  // One decoded measurement of the held packet
  typedef struct packed {
    logic [ANG_W-1:0]   angle;
    logic [DIST_W-1:0]  distance;
    logic [SPEED_W-1:0] speed;
  } lpd_meas_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MEAS,
    ST_SCAN,
    ST_SCAN_OUT
  } lpd_state_t;

endpackage

// ===== rtl/lpd_dist_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lpd_dist_ram #(
  parameter int DEPTH = 360,
  parameter int WIDTH = 14
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/lpd_pkt_asm.sv =====
// Packet assembler: frames serial bytes, holds the packet and decodes one measurement.
module lpd_pkt_asm (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                byte_vld,
  input  logic [7:0]                          rx_byte,
  input  logic [lpd_pkg::MEAS_IDX_W-1:0]      meas_idx,
  output logic                                pkt_last,
  output lpd_pkg::lpd_meas_t                  meas
);
  import lpd_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_LENGTH - 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             wr;
  logic [7:0]       pkt_r [PACKET_LENGTH];

  logic [POS_W-1:0]     lo_idx, hi_idx;
  logic [7:0]           lo_byte, hi_byte, base;
  logic [RAW_ANG_W-1:0] raw_ang, ang_mod;

  // Framing: 0xFA opens a packet only while idle
  always_comb begin
    pos_nxt = pos_r;
    wr      = 1'b0;
    if (byte_vld) begin
      if (pos_r == '0) begin
        if (rx_byte == START_BYTE) begin
          wr      = 1'b1;
          pos_nxt = POS_W'(1);
        end
      end else begin
        wr = 1'b1;
        if (pos_r == LAST_POS) begin
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  // The next byte taken completes the packet
  assign pkt_last = (pos_r == LAST_POS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Packet byte store
  always_ff @(posedge clk) begin
    if (wr) begin
      pkt_r[pos_r] <= rx_byte;
    end
  end

  // Decode the selected measurement
  always_comb begin
    lo_idx  = POS_W'(4) + POS_W'({meas_idx, 2'b00});
    hi_idx  = lo_idx + POS_W'(1);
    lo_byte = pkt_r[lo_idx];
    hi_byte = pkt_r[hi_idx];
    base    = pkt_r[1] - ANGLE_BASE;
    raw_ang = {base, 2'b00} + RAW_ANG_W'(meas_idx);
    // raw angle stays below three turns
    if (raw_ang >= RAW_ANG_W'(2 * ANGLE_BINS)) begin
      ang_mod = raw_ang - RAW_ANG_W'(2 * ANGLE_BINS);
    end else if (raw_ang >= RAW_ANG_W'(ANGLE_BINS)) begin
      ang_mod = raw_ang - RAW_ANG_W'(ANGLE_BINS);
    end else begin
      ang_mod = raw_ang;
    end
    meas.angle = ang_mod[ANG_W-1:0];
    if (hi_byte[INVALID_BIT]) begin
      meas.distance = '0;
    end else begin
      meas.distance = {hi_byte[5:0], lo_byte};
    end
    meas.speed = {pkt_r[3], pkt_r[2]};
  end

endmodule

// ===== rtl/lidar_packet_decoder.sv =====
// Top level of the lidar packet decoder: sequencer, distance table and result register.
// Byte items are taken while the block is idle. The byte that completes a packet gives four
// measurement items, one per cycle while the output is free, and a nonzero distance is
// written into the 360-entry distance table RAM as its measurement leaves; the next input
// item is taken after the fourth. A scan item reads the table through its single read port,
// one entry a cycle, and its result is loaded once the final read is folded in. After
// reset the block runs a clearing pass over all 360 table entries before it takes any
// input item; configuration writes are taken at any time.
`include "lidar_packet_decoder_assert.svh"
module lidar_packet_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_kind,
  output logic [lpd_pkg::ANG_W-1:0]       out_angle,
  output logic [lpd_pkg::DIST_W-1:0]      out_distance,
  output logic                            out_stored,
  output logic [lpd_pkg::SPEED_W-1:0]     out_speed_raw,
  output logic [lpd_pkg::DIST_W-1:0]      out_min_distance,
  output logic [lpd_pkg::DIST_W-1:0]      out_max_distance,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lpd_pkg::DIST_W-1:0]      cfg_min_ceiling
);
  import lpd_pkg::*;

  localparam logic [ANG_W-1:0]      LAST_BIN  = ANG_W'(ANGLE_BINS - 1);
  localparam logic [MEAS_IDX_W-1:0] LAST_MEAS = MEAS_IDX_W'(MEAS_PER_PKT - 1);

  lpd_state_t            state_r, state_nxt;
  logic [MEAS_IDX_W-1:0] idx_r, idx_nxt;
  logic [ANG_W-1:0]      addr_r, addr_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [DIST_W-1:0]     mn_r, mn_nxt, mx_r, mx_nxt;
  logic [DIST_W-1:0]     ceil_r;

  logic              byte_vld, pkt_last;
  lpd_meas_t         meas;
  logic              wr_en;
  logic [ANG_W-1:0]  wr_addr;
  logic [DIST_W-1:0] wr_data, rd_data;

  logic              out_free, out_ld;
  logic              out_valid_r, out_valid_nxt;
  logic              kind_nxt, stored_nxt, last_nxt;
  logic [ANG_W-1:0]  angle_nxt;
  logic [DIST_W-1:0] dist_nxt, min_nxt, max_nxt;
  logic [SPEED_W-1:0] speed_nxt;
  logic              kind_r, stored_r, last_r;
  logic [ANG_W-1:0]  angle_r;
  logic [DIST_W-1:0] dist_r, min_r, max_r;
  logic [SPEED_W-1:0] speed_r;

  lpd_pkt_asm u_pkt_asm (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (byte_vld),
    .rx_byte  (in_rx_byte),
    .meas_idx (idx_r),
    .pkt_last (pkt_last),
    .meas     (meas)
  );

  lpd_dist_ram #(
    .DEPTH (ANGLE_BINS),
    .WIDTH (DIST_W)
  ) u_dist_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r <= CEILING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ceil_r <= cfg_min_ceiling;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // Sequencer: table clear, byte intake, measurement emit, table scan
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    addr_nxt   = addr_r;
    rd_vld_nxt = 1'b0;
    in_stall   = 1'b1;
    byte_vld   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = addr_r;
    wr_data    = '0;
    out_ld     = 1'b0;
    kind_nxt   = KIND_MEAS;
    angle_nxt  = '0;
    dist_nxt   = '0;
    stored_nxt = 1'b0;
    speed_nxt  = '0;
    min_nxt    = '0;
    max_nxt    = '0;
    last_nxt   = 1'b0;

    // running min and max over nonzero table entries
    mn_nxt = mn_r;
    mx_nxt = mx_r;
    if (rd_vld_r && (rd_data != '0)) begin
      if (rd_data < mn_r) begin
        mn_nxt = rd_data;
      end
      if (rd_data > mx_r) begin
        mx_nxt = rd_data;
      end
    end

    unique case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
        if (addr_r == LAST_BIN) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + ANG_W'(1);
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_mode == MODE_SCAN) begin
            addr_nxt  = '0;
            mn_nxt    = ceil_r;
            mx_nxt    = '0;
            state_nxt = ST_SCAN;
          end else begin
            byte_vld = 1'b1;
            if (pkt_last) begin
              idx_nxt   = '0;
              state_nxt = ST_MEAS;
            end
          end
        end
      end
      ST_MEAS: begin
        if (out_free) begin
          out_ld     = 1'b1;
          kind_nxt   = KIND_MEAS;
          angle_nxt  = meas.angle;
          dist_nxt   = meas.distance;
          stored_nxt = (meas.distance != '0);
          speed_nxt  = meas.speed;
          last_nxt   = (idx_r == LAST_MEAS);
          wr_en      = (meas.distance != '0);
          wr_addr    = meas.angle;
          wr_data    = meas.distance;
          idx_nxt    = idx_r + MEAS_IDX_W'(1);
          if (idx_r == LAST_MEAS) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        rd_vld_nxt = 1'b1;
        if (addr_r == LAST_BIN) begin
          addr_nxt  = '0;
          state_nxt = ST_SCAN_OUT;
        end else begin
          addr_nxt = addr_r + ANG_W'(1);
        end
      end
      ST_SCAN_OUT: begin
        // wait for the final read to be folded in
        if (!rd_vld_r && out_free) begin
          out_ld    = 1'b1;
          kind_nxt  = KIND_SCAN;
          min_nxt   = mn_r;
          max_nxt   = mx_r;
          last_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      addr_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      addr_r      <= addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scan accumulators and result register
  always_ff @(posedge clk) begin
    mn_r <= mn_nxt;
    mx_r <= mx_nxt;
    if (out_ld) begin
      kind_r   <= kind_nxt;
      angle_r  <= angle_nxt;
      dist_r   <= dist_nxt;
      stored_r <= stored_nxt;
      speed_r  <= speed_nxt;
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_angle        = angle_r;
  assign out_distance     = dist_r;
  assign out_stored       = stored_r;
  assign out_speed_raw    = speed_r;
  assign out_min_distance = min_r;
  assign out_max_distance = max_r;
  assign out_last         = last_r;

  // Checks
  `LPD_ASSERT(a_wr_state, wr_en |-> (state_r == ST_MEAS || state_r == ST_CLEAR))
  `LPD_ASSERT(a_meas_exit, (state_r == ST_MEAS && state_nxt == ST_IDLE) |-> idx_r == LAST_MEAS)
  `LPD_ASSERT(a_scan_order, (out_valid_r && kind_r == KIND_SCAN && max_r != '0) |-> min_r <= max_r)
  `LPD_ASSERT_NEXT(a_scan_start, state_r == ST_IDLE && in_valid && in_mode == MODE_SCAN, state_r == ST_SCAN && addr_r == '0)

endmodule

// ===== verif/tb_lidar_packet_decoder.sv =====
// Self-checking testbench of the lidar packet decoder: directed table, then random traffic.
module tb_lidar_packet_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import lpd_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_DIRECTED     = 27;

  // One result item as the decoder should emit it
  typedef struct packed {
    logic               kind;
    logic [ANG_W-1:0]   angle;
    logic [DIST_W-1:0]  distance;
    logic               stored;
    logic [SPEED_W-1:0] speed_raw;
    logic [DIST_W-1:0]  min_distance;
    logic [DIST_W-1:0]  max_distance;
    logic               last;
  } lidar_result_t;

  // Directed row: typed rows carry the scan result that is obvious by eye
  typedef struct packed {
    logic              mode;
    logic [7:0]        rx;
    logic              typed;
    logic [DIST_W-1:0] tmin;
    logic [DIST_W-1:0] tmax;
  } stim_row_t;

  // Empty-table scan, dropped idle bytes, one packet with extreme fields, a scan
  // mid-packet, then a scan of the filled table
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{MODE_SCAN, 8'h00, 1'b1, 14'd2000, 14'd0},
    '{MODE_BYTE, 8'h00, 1'b0, 14'd0, 14'd0},
    '{MODE_BYTE, 8'hFF, 1'b0, 14'd0, 14'd0},
    '{MODE_BYTE, 8'hFA, 1'b0, 14'd0, 14'd0},     // start
    '{MODE_BYTE, 8'hFA, 1'b0, 14'd0, 14'd0},     // angle byte, wraps past 359
    '{MODE_BYTE, 8'hFF, 1'b0, 14'd0, 14'd0},     // speed low
    '{MODE_BYTE, 8'hFF, 1'b0, 14'd0, 14'd0},     // speed high
    '{MODE_BYTE, 8'hFF, 1'b0, 14'd0, 14'd0},     // full-scale distance
    '{MODE_BYTE, 8'h3F, 1'b0, 14'd0, 14'd0},
    '{MODE_BYTE, 8'h00, 1'b0, 14'd0, 14'd0},
    '{MODE_BYTE, 8'hFF, 1'b0, 14'd0, 14'd0},
    '{MODE_BYTE, 8'h12, 1'b0, 14'd0, 14'd0},     // flagged invalid
    '{MODE_BYTE, 8'h80, 1'b0, 14'd0, 14'd0},
    '{MODE_SCAN, 8'hFF, 1'b1, 14'd2000, 14'd0},  // packet in progress is kept
    '{MODE_BYTE, 8'hFA, 1'b0, 14'd0, 14'd0},
    '{MODE_BYTE, 8'h00, 1'b0, 14'd0, 14'd0},
    '{MODE_BYTE, 8'h00, 1'b0, 14'd0, 14'd0},     // zero distance
    '{MODE_BYTE, 8'h00, 1'b0, 14'd0, 14'd0},
    '{MODE_BYTE, 8'h55, 1'b0, 14'd0, 14'd0},
    '{MODE_BYTE, 8'hAA, 1'b0, 14'd0, 14'd0},
    '{MODE_BYTE, 8'h01, 1'b0, 14'd0, 14'd0},     // smallest distance, bit 6 ignored
    '{MODE_BYTE, 8'h40, 1'b0, 14'd0, 14'd0},
    '{MODE_BYTE, 8'h00, 1'b0, 14'd0, 14'd0},
    '{MODE_BYTE, 8'hFF, 1'b0, 14'd0, 14'd0},
    '{MODE_BYTE, 8'h00, 1'b0, 14'd0, 14'd0},
    '{MODE_BYTE, 8'hFF, 1'b0, 14'd0, 14'd0},     // completes the packet
    '{MODE_SCAN, 8'h00, 1'b1, 14'd1, 14'd16383}
  };

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic                in_mode          = MODE_BYTE;
  logic [7:0]          in_rx_byte       = 8'h00;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic                out_kind;
  logic [ANG_W-1:0]    out_angle;
  logic [DIST_W-1:0]   out_distance;
  logic                out_stored;
  logic [SPEED_W-1:0]  out_speed_raw;
  logic [DIST_W-1:0]   out_min_distance;
  logic [DIST_W-1:0]   out_max_distance;
  logic                out_last;
  logic                cfg_valid        = 1'b0;
  logic                cfg_ready;
  logic [DIST_W-1:0]   cfg_min_ceiling  = '0;

  // Decoder state as predicted
  logic [DIST_W-1:0]   ceiling;
  logic [POS_W-1:0]    pkt_pos;
  logic [7:0]          pkt_bytes [PACKET_LENGTH];
  logic [DIST_W-1:0]   range_table [ANGLE_BINS];
  lidar_result_t       results_due [$];

  int                  mismatches   = 0;
  int                  quiet_cycles = 0;
  int                  stall_left   = 0;
  logic                calm         = 1'b0;

  lidar_packet_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_angle        (out_angle),
    .out_distance     (out_distance),
    .out_stored       (out_stored),
    .out_speed_raw    (out_speed_raw),
    .out_min_distance (out_min_distance),
    .out_max_distance (out_max_distance),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_min_ceiling  (cfg_min_ceiling)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t ns: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Works out the results of one accepted input item and advances the state
  task automatic decode_item(input logic mode, input logic [7:0] rx);
    lidar_result_t           res;
    logic [DIST_W-1:0]       lo_dist, hi_dist;
    logic [7:0]              base, lo, hi;
    logic [RAW_ANG_W-1:0]    raw_angle;
    res = '0;
    if (mode == MODE_SCAN) begin
      lo_dist = ceiling;
      hi_dist = '0;
      for (int a = 0; a < ANGLE_BINS; a++) begin
        if (range_table[a] != 0) begin
          if (range_table[a] < lo_dist) lo_dist = range_table[a];
          if (range_table[a] > hi_dist) hi_dist = range_table[a];
        end
      end
      res.kind         = KIND_SCAN;
      res.min_distance = lo_dist;
      res.max_distance = hi_dist;
      res.last         = 1'b1;
      results_due.push_back(res);
    end else if (pkt_pos == 0) begin
      // idle: only the start byte opens a packet
      if (rx == START_BYTE) begin
        pkt_bytes[0] = rx;
        pkt_pos      = 1;
      end
    end else begin
      pkt_bytes[pkt_pos] = rx;
      if (pkt_pos != POS_W'(PACKET_LENGTH - 1)) begin
        pkt_pos++;
      end else begin
        pkt_pos = 0;
        base    = pkt_bytes[1] - ANGLE_BASE;
        for (int m = 0; m < MEAS_PER_PKT; m++) begin
          lo        = pkt_bytes[4 + 4 * m];
          hi        = pkt_bytes[5 + 4 * m];
          raw_angle = {base, 2'b00} + RAW_ANG_W'(m);
          res       = '0;
          res.kind      = KIND_MEAS;
          res.angle     = ANG_W'(raw_angle % ANGLE_BINS);
          res.distance  = hi[INVALID_BIT] ? '0 : {hi[5:0], lo};
          res.speed_raw = {pkt_bytes[3], pkt_bytes[2]};
          res.last      = (m == MEAS_PER_PKT - 1);
          if (res.distance != 0) begin
            range_table[res.angle] = res.distance;
            res.stored             = 1'b1;
          end
          results_due.push_back(res);
        end
      end
    end
  endtask

  // Presents one item, with an occasional gap first, and returns on the edge it is taken
  task automatic offer_item(input logic mode, input logic [7:0] rx);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_rx_byte <= rx;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic feed_item(input logic mode, input logic [7:0] rx);
    offer_item(mode, rx);
    decode_item(mode, rx);
  endtask

  // Sender holds off until every due result is in, then lets the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ceiling(input logic [DIST_W-1:0] value);
    cfg_valid       <= 1'b1;
    cfg_min_ceiling <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ceiling    = value;
  endtask

  // Mostly whole packets with random content; scans, mid-packet scans and line noise
  task automatic random_phase(input int quota);
    logic [7:0] pkt [PACKET_LENGTH];
    int         sent;
    int         pick;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        pkt[0] = START_BYTE;
        for (int k = 1; k < PACKET_LENGTH; k++) pkt[k] = 8'($urandom);
        for (int m = 0; m < MEAS_PER_PKT; m++) begin
          pkt[5 + 4 * m][INVALID_BIT] = ($urandom_range(0, 3) == 0);
          if ($urandom_range(0, 3) == 0) pkt[5 + 4 * m][5:0] = '0;
          if ($urandom_range(0, 7) == 0) begin
            pkt[4 + 4 * m]      = '0;
            pkt[5 + 4 * m][5:0] = '0;
          end
        end
        for (int k = 0; k < PACKET_LENGTH; k++) begin
          feed_item(MODE_BYTE, pkt[k]);
          if (k > 0 && $urandom_range(0, 29) == 0) begin
            feed_item(MODE_SCAN, 8'($urandom));
            sent++;
          end
        end
        sent += PACKET_LENGTH;
      end else if (pick <= 7) begin
        feed_item(MODE_SCAN, 8'($urandom));
        sent++;
      end else begin
        // noise: idle bytes are dropped, a stray start byte opens a broken packet
        pick = $urandom_range(1, 3);
        repeat (pick) feed_item(MODE_BYTE, 8'($urandom));
        sent += pick;
      end
    end
    feed_item(MODE_SCAN, 8'($urandom));
  endtask

  // Result side: bursts of stall, none once the run is calm
  always @(posedge clk) begin
    if (calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest one due
  always @(posedge clk) begin : collect
    lidar_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch("result item with nothing due");
      end else begin
        want = results_due.pop_front();
        check_field("kind", out_kind, want.kind);
        check_field("angle", out_angle, want.angle);
        check_field("distance", out_distance, want.distance);
        check_field("stored", out_stored, want.stored);
        check_field("speed_raw", out_speed_raw, want.speed_raw);
        check_field("min_distance", out_min_distance, want.min_distance);
        check_field("max_distance", out_max_distance, want.max_distance);
        check_field("last", out_last, want.last);
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
    begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    lidar_result_t typed_res;
    ceiling = CEILING_RESET;
    pkt_pos = '0;
    foreach (range_table[a]) range_table[a] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < N_DIRECTED; r++) begin
      offer_item(DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].rx);
      if (DIRECTED_ROWS[r].typed) begin
        typed_res              = '0;
        typed_res.kind         = KIND_SCAN;
        typed_res.min_distance = DIRECTED_ROWS[r].tmin;
        typed_res.max_distance = DIRECTED_ROWS[r].tmax;
        typed_res.last         = 1'b1;
        results_due.push_back(typed_res);
      end else begin
        decode_item(DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].rx);
      end
    end
    drain();

    // random phases under several ceilings, extremes first
    write_ceiling('0);
    random_phase(30);
    drain();
    write_ceiling('1);
    random_phase(30);
    drain();
    write_ceiling(DIST_W'($urandom_range(1, 16382)));
    random_phase(30);
    drain();
    calm = 1'b1;
    write_ceiling(CEILING_RESET);
    random_phase(30);
    drain();

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lpd_pkg.sv
rtl/lpd_dist_ram.sv
rtl/lpd_pkt_asm.sv
rtl/lidar_packet_decoder.sv
verif/tb_lidar_packet_decoder.sv
